@@ sv/rga_pkg.sv @@
// ----------------------------------------------------------------------------
// rga_pkg
// shared types and codes for the rational arithmetic gcd reduce block
// ----------------------------------------------------------------------------
package rga_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SUB    = 2'd1,
        OP_MUL    = 2'd2,
        OP_REDUCE = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    // request and status between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;

endpackage

@@ sv/rga_divider.sv @@
// ----------------------------------------------------------------------------
// rga_divider
// shared 64-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rga_divider
    import rga_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    // load on start, else one restoring step while busy
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

    // done only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg))
        else $error("divider done without busy");

    // counter zero when idle
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 7'd0)
        else $error("divider count left over");

    // start begins a run
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not start");

endmodule

@@ sv/rational_arith_gcd_reduce.sv @@
// ----------------------------------------------------------------------------
// rational_arith_gcd_reduce
// signed fraction add, subtract, multiply or reduce with euclidean gcd
// ----------------------------------------------------------------------------
// One beat at a time. After acceptance, the cross products come from one
// shared 32x32 multiplier in ST_MUL0, ST_MUL1 and ST_MUL2, then the
// magnitudes are combined. The gcd is found by Euclid's algorithm on one
// shared 64-bit divider that gives one quotient bit per cycle; the
// numerator and denominator are then divided by the gcd on the same unit.
// Reduce skips the multiplier. A 0/0 result skips the divider altogether.
// in_stall stays high from acceptance until the result beat has been taken.
module rational_arith_gcd_reduce
    import rga_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               overflow,
    output logic               undefined_zero
);

    state_t state_reg, state_next;
    op_t    op_reg;
    logic   ok;

    logic [31:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic        an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [63:0] p_reg, q_reg;
    logic [63:0] nm_reg, dm_reg;
    logic        ns_reg, ds_reg;
    logic [63:0] gp_reg, gq_reg;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic        p_neg, q_neg;
    logic        dstarted_reg;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic [63:0] rn_reg, rd_reg;
    logic        out_valid_reg, uz_reg;

    localparam logic [63:0] LIMIT = 64'd1 << (WIDTH - 1);

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    assign ok = in_valid && !in_stall;

    // shared multiplier operand select
    always_comb
    begin
        ma = an_m_reg;
        mb = bd_m_reg;
        unique case (state_reg)
            ST_MUL0:
            begin
                ma = an_m_reg;
                mb = (op_reg == OP_MUL) ? bn_m_reg : bd_m_reg;
            end
            ST_MUL1:
            begin
                ma = bn_m_reg;
                mb = ad_m_reg;
            end
            ST_MUL2:
            begin
                ma = ad_m_reg;
                mb = bd_m_reg;
            end
            default:
            begin
                ma = an_m_reg;
                mb = bd_m_reg;
            end
        endcase
    end

    assign prod  = {32'd0, ma} * {32'd0, mb};
    assign p_neg = (op_reg == OP_MUL) ? (an_s_reg ^ bn_s_reg) : (an_s_reg ^ bd_s_reg);
    assign q_neg = (bn_s_reg ^ ad_s_reg) ^ (op_reg == OP_SUB);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ok) state_next = (kind == OP_REDUCE) ? ST_COMB : ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_COMB;
            ST_COMB: state_next = ST_GCD;
            ST_GCD:
            begin
                if (nm_reg == 64'd0 && dm_reg == 64'd0) state_next = ST_DONE;
                else if (gq_reg == 64'd0 && !dstarted_reg) state_next = ST_DIVN;
            end
            ST_DIVN: if (drsp.done) state_next = ST_DIVD;
            ST_DIVD: if (drsp.done) state_next = ST_DONE;
            ST_DONE: if (out_valid_reg && !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // divider request, the gcd sits in gp once euclid has finished
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = gp_reg;
        dreq.divisor  = gq_reg;
        unique case (state_reg)
            ST_GCD:
            begin
                dreq.start = !dstarted_reg && gq_reg != 64'd0 && !drsp.busy
                             && !(nm_reg == 64'd0 && dm_reg == 64'd0);
            end
            ST_DIVN:
            begin
                dreq.dividend = nm_reg;
                dreq.divisor  = gp_reg;
                dreq.start    = !dstarted_reg;
            end
            ST_DIVD:
            begin
                dreq.dividend = dm_reg;
                dreq.divisor  = gp_reg;
                dreq.start    = !dstarted_reg;
            end
            default: dreq.start = 1'b0;
        endcase
    end

    rga_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dstarted_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next) dstarted_reg <= 1'b0;
            else if (dreq.start) dstarted_reg <= 1'b1;
            else if (drsp.done) dstarted_reg <= 1'b0;
            if (state_reg == ST_DONE && !out_valid_reg) out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ok)
                begin
                    op_reg   <= op_t'(kind);
                    an_m_reg <= mag32(a_num);
                    ad_m_reg <= mag32(a_den);
                    bn_m_reg <= mag32(b_num);
                    bd_m_reg <= mag32(b_den);
                    an_s_reg <= a_num[31];
                    ad_s_reg <= a_den[31];
                    bn_s_reg <= b_num[31];
                    bd_s_reg <= b_den[31];
                end
            end
            ST_MUL0: p_reg <= prod;
            ST_MUL1: q_reg <= prod;
            ST_MUL2: dm_reg <= prod;
            ST_COMB:
            begin
                if (op_reg == OP_REDUCE)
                begin
                    nm_reg <= {32'd0, an_m_reg};
                    ns_reg <= an_s_reg;
                    dm_reg <= {32'd0, ad_m_reg};
                    ds_reg <= ad_s_reg;
                    gp_reg <= (an_m_reg >= ad_m_reg) ? {32'd0, an_m_reg} : {32'd0, ad_m_reg};
                    gq_reg <= (an_m_reg >= ad_m_reg) ? {32'd0, ad_m_reg} : {32'd0, an_m_reg};
                end
                else
                begin
                    ds_reg <= ad_s_reg ^ bd_s_reg;
                    if (op_reg == OP_MUL)
                    begin
                        nm_reg <= p_reg;
                        ns_reg <= p_neg;
                        gp_reg <= (p_reg >= dm_reg) ? p_reg : dm_reg;
                        gq_reg <= (p_reg >= dm_reg) ? dm_reg : p_reg;
                    end
                    else
                    begin
                        // magnitude sum, sign as from the larger term
                        if (p_neg == q_neg)
                        begin
                            nm_reg <= p_reg + q_reg;
                            ns_reg <= p_neg;
                        end
                        else if (p_reg >= q_reg)
                        begin
                            nm_reg <= p_reg - q_reg;
                            ns_reg <= p_neg;
                        end
                        else
                        begin
                            nm_reg <= q_reg - p_reg;
                            ns_reg <= q_neg;
                        end
                        // gcd order is fixed after the first remainder step
                        gp_reg <= dm_reg;
                        gq_reg <= (p_neg == q_neg) ? p_reg + q_reg
                                : (p_reg >= q_reg) ? p_reg - q_reg : q_reg - p_reg;
                    end
                end
            end
            ST_GCD:
            begin
                if (drsp.done && dstarted_reg)
                begin
                    gp_reg <= gq_reg;
                    gq_reg <= drsp.rem;
                end
            end
            ST_DIVN: if (drsp.done && dstarted_reg) rn_reg <= drsp.quot;
            ST_DIVD: if (drsp.done && dstarted_reg) rd_reg <= drsp.quot;
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    uz_reg <= nm_reg == 64'd0 && dm_reg == 64'd0;
                    if (nm_reg == 64'd0 && dm_reg == 64'd0)
                    begin
                        rn_reg <= '0;
                        rd_reg <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // wrap to WIDTH and sign-extend
    function automatic logic [31:0] emit(input logic neg, input logic [63:0] m);
        logic [63:0] w;
        w = neg ? (64'd0 - m) : m;
        emit = 32'(w[WIDTH-1:0]);
        for (int i = WIDTH; i < 32; i++) emit[i] = w[WIDTH-1];
    endfunction

    function automatic logic ovf(input logic neg, input logic [63:0] m);
        ovf = (m != 64'd0) && (neg ? (m > LIMIT) : (m >= LIMIT));
    endfunction

    assign in_stall       = state_reg != ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign res_num        = emit(ns_reg, rn_reg);
    assign res_den        = emit(ds_reg, rd_reg);
    assign overflow       = ovf(ns_reg, rn_reg) || ovf(ds_reg, rd_reg);
    assign undefined_zero = uz_reg;

    // result only shown in the final state
    a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_DONE)
        else $error("result outside done");

    // no new item while a result is pending
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open with result pending");

    // 0/0 flag means zero outputs
    a_uz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && undefined_zero) |-> (res_num == 32'd0 && res_den == 32'd0))
        else $error("0/0 result not zero");

endmodule
